// ----- rtl/gufk_pkg.sv -----
// gufk_pkg: shared types and constants for the grid union-find Kruskal engine.
// No dependencies.
`default_nettype none
package gufk_pkg;
  localparam int MAX_CELLS_DEF = 1024;
  localparam int DIM_W = 6;
  localparam int COORD_W = 5;
  localparam int CNT_W = 11;
  localparam int GRID_DIM_MAX = 32;
  // Epoch tag width in the parent memory; a wrap forces a clearing sweep.
  localparam int EPOCH_W = 4;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_EDGE  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_WAIT,
    ST_CHK,
    ST_CMP_RD,
    ST_CMP_WAIT,
    ST_CMP_WR,
    ST_LINK,
    ST_OUT
  } bk_state_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic        is_clear;
    logic        bad;
    logic [15:0] ia;
    logic [15:0] ib;
  } job_t;
endpackage
`default_nettype wire

// ----- rtl/gufk_front.sv -----
// gufk_front: accepts items, checks coordinates, forms cell indexes, two-entry queue.
// Depends on gufk_pkg.
`default_nettype none
module gufk_front #(
  parameter int MAX_CELLS = gufk_pkg::MAX_CELLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_a_row,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_a_col,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_b_row,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_b_col,
  input  wire logic [gufk_pkg::DIM_W-1:0]    rows,
  input  wire logic [gufk_pkg::DIM_W-1:0]    cols,
  output logic                               job_valid,
  input  wire logic                          job_take,
  output gufk_pkg::job_t                     job
);
  logic [11:0] ia_full, ib_full;
  logic        bad_a, bad_b;
  gufk_pkg::job_t new_job;
  gufk_pkg::job_t q_r [2];
  logic           rd_ptr_r, wr_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;

  // Index is row * cols + col; 5x6 product is narrow.
  assign ia_full = 12'(in_a_row) * 12'(cols) + 12'(in_a_col);
  assign ib_full = 12'(in_b_row) * 12'(cols) + 12'(in_b_col);
  assign bad_a = ({1'b0, in_a_row} >= rows) || ({1'b0, in_a_col} >= cols) ||
                 (32'(ia_full) >= MAX_CELLS);
  assign bad_b = ({1'b0, in_b_row} >= rows) || ({1'b0, in_b_col} >= cols) ||
                 (32'(ib_full) >= MAX_CELLS);

  always_comb begin
    new_job.is_clear = (in_cmd == gufk_pkg::CMD_CLEAR);
    new_job.bad = (in_cmd == gufk_pkg::CMD_EDGE) && (bad_a || bad_b);
    new_job.ia = 16'(ia_full);
    new_job.ib = 16'(ib_full);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_job;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (job_take) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(job_take);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("take from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> in_stall) else $error("full queue not stalling");
endmodule
`default_nettype wire

// ----- rtl/gufk_back.sv -----
// gufk_back: union-find engine over the parent memory with path compression.
// Depends on gufk_pkg.
`default_nettype none
module gufk_back #(
  parameter int MAX_CELLS = gufk_pkg::MAX_CELLS_DEF,
  parameter int IDX_W = $clog2(MAX_CELLS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        job_valid,
  output logic                             job_take,
  input  gufk_pkg::job_t                   job,
  input  wire logic [gufk_pkg::DIM_W-1:0]  rows,
  input  wire logic [gufk_pkg::DIM_W-1:0]  cols,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_accepted,
  output logic [gufk_pkg::CNT_W-1:0]       out_clusters_left,
  output logic                             out_tree_done,
  output logic                             out_bad_coord
);
  localparam int CELL_CAP = (MAX_CELLS > 1024) ? 1024 : MAX_CELLS;

  // Memory: parent index plus epoch tag; an entry whose tag differs is self parent.
  logic [IDX_W-1:0]             par_mem [MAX_CELLS];
  logic [gufk_pkg::EPOCH_W-1:0] ep_mem  [MAX_CELLS];
  logic [IDX_W-1:0]             rd_par_r;
  logic [gufk_pkg::EPOCH_W-1:0] rd_ep_r;
  logic [IDX_W-1:0] rd_addr, wr_addr, wr_data;
  logic             wr_en;

  gufk_pkg::bk_state_t st_r, st_nxt;
  logic [IDX_W-1:0] x_r, x_nxt, r_r, r_nxt, ra_r, ra_nxt, start_r, start_nxt;
  logic [IDX_W-1:0] ib_r, ib_nxt;
  logic             side_r, side_nxt;
  logic [gufk_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic             fresh_r, fresh_nxt;
  logic [IDX_W:0]   clr_r, clr_nxt;
  logic [gufk_pkg::CNT_W-1:0] count_r, count_nxt;
  logic             acc_r, acc_nxt, bad_r, bad_nxt;
  logic [IDX_W-1:0] par_eff;
  logic [11:0]      cells;

  assign cells = 12'(rows) * 12'(cols);
  // Parent seen through the epoch tag; stale means self.
  assign par_eff = (rd_ep_r == epoch_r && !fresh_r) ? rd_par_r : x_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      par_mem[wr_addr] <= wr_data;
      ep_mem[wr_addr] <= epoch_r;
    end
    rd_par_r <= par_mem[rd_addr];
    rd_ep_r <= ep_mem[rd_addr];
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      gufk_pkg::ST_IDLE:
        if (job_valid) begin
          if (fresh_r) st_nxt = gufk_pkg::ST_CLR;
          else if (job.is_clear || job.bad) st_nxt = gufk_pkg::ST_OUT;
          else st_nxt = gufk_pkg::ST_RD;
        end
      gufk_pkg::ST_CLR:
        if (clr_r == (IDX_W+1)'(MAX_CELLS - 1)) st_nxt = gufk_pkg::ST_IDLE;
      gufk_pkg::ST_RD: st_nxt = gufk_pkg::ST_WAIT;
      gufk_pkg::ST_WAIT: st_nxt = gufk_pkg::ST_CHK;
      gufk_pkg::ST_CHK:
        if (par_eff != x_r) st_nxt = gufk_pkg::ST_RD;
        else st_nxt = gufk_pkg::ST_CMP_RD;
      gufk_pkg::ST_CMP_RD:
        if (x_r == r_r) st_nxt = side_r ? gufk_pkg::ST_LINK : gufk_pkg::ST_RD;
        else st_nxt = gufk_pkg::ST_CMP_WAIT;
      gufk_pkg::ST_CMP_WAIT: st_nxt = gufk_pkg::ST_CMP_WR;
      gufk_pkg::ST_CMP_WR: st_nxt = gufk_pkg::ST_CMP_RD;
      gufk_pkg::ST_LINK: st_nxt = gufk_pkg::ST_OUT;
      gufk_pkg::ST_OUT: if (!out_stall) st_nxt = gufk_pkg::ST_IDLE;
      default: st_nxt = gufk_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    x_nxt = x_r; r_nxt = r_r; ra_nxt = ra_r; start_nxt = start_r; ib_nxt = ib_r;
    side_nxt = side_r; epoch_nxt = epoch_r; fresh_nxt = fresh_r;
    clr_nxt = clr_r; count_nxt = count_r; acc_nxt = acc_r; bad_nxt = bad_r;
    rd_addr = x_r; wr_addr = x_r; wr_data = r_r; wr_en = 1'b0;
    job_take = 1'b0;
    unique case (st_r)
      gufk_pkg::ST_IDLE:
        if (job_valid && !fresh_r) begin
          job_take = 1'b1;
          acc_nxt = 1'b0;
          bad_nxt = job.bad;
          side_nxt = 1'b0;
          x_nxt = job.ia[IDX_W-1:0];
          start_nxt = job.ia[IDX_W-1:0];
          ib_nxt = job.ib[IDX_W-1:0];
          if (job.is_clear) begin
            // New epoch; on wrap, sweep the memory before the next transaction.
            epoch_nxt = epoch_r + 1'b1;
            if (epoch_r == '1) fresh_nxt = 1'b1;
            count_nxt = (32'(cells) > CELL_CAP) ? gufk_pkg::CNT_W'(CELL_CAP)
                                                : gufk_pkg::CNT_W'(cells);
          end
        end
      gufk_pkg::ST_CLR: begin
        // Sweep points every entry at itself.
        wr_en = 1'b1;
        wr_addr = clr_r[IDX_W-1:0];
        wr_data = clr_r[IDX_W-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IDX_W+1)'(MAX_CELLS - 1)) begin
          fresh_nxt = 1'b0;
          clr_nxt = '0;
          epoch_nxt = gufk_pkg::EPOCH_W'(1);
        end
      end
      gufk_pkg::ST_CHK: begin
        if (par_eff != x_r) x_nxt = par_eff;
        else begin
          r_nxt = x_r;
          x_nxt = start_r;
        end
      end
      gufk_pkg::ST_CMP_RD:
        if (x_r == r_r) begin
          if (!side_r) begin
            ra_nxt = r_r;
            side_nxt = 1'b1;
            x_nxt = ib_r;
            start_nxt = ib_r;
          end
        end
      gufk_pkg::ST_CMP_WR: begin
        wr_en = 1'b1;
        x_nxt = par_eff;
      end
      gufk_pkg::ST_LINK:
        if (ra_r != r_r) begin
          wr_en = 1'b1;
          wr_addr = ra_r;
          acc_nxt = 1'b1;
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
      default: ;
    endcase
  end

  // Output decode
  always_comb begin
    out_valid = (st_r == gufk_pkg::ST_OUT);
    out_accepted = acc_r;
    out_bad_coord = bad_r;
    out_clusters_left = count_r;
    out_tree_done = (count_r <= gufk_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gufk_pkg::ST_IDLE;
      epoch_r <= '0;
      fresh_r <= 1'b1;
      clr_r <= '0;
      count_r <= (MAX_CELLS > 1024) ? gufk_pkg::CNT_W'(1024)
                                    : gufk_pkg::CNT_W'(MAX_CELLS);
    end else begin
      st_r <= st_nxt;
      epoch_r <= epoch_nxt;
      fresh_r <= fresh_nxt;
      clr_r <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; r_r <= r_nxt; ra_r <= ra_nxt; start_r <= start_nxt; ib_r <= ib_nxt;
    side_r <= side_nxt; acc_r <= acc_nxt; bad_r <= bad_nxt;
  end

  a_acc_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_bad_coord)) else $error("accept with bad coord");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 1024) else $error("cluster count above cap");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> st_r == gufk_pkg::ST_IDLE) else $error("take while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ----- rtl/grid_union_find_kruskal.sv -----
// grid_union_find_kruskal: top level; config registers, front classifier, back engine.
// Depends on gufk_pkg, gufk_front, gufk_back.
//
//  port group   dir      transaction
//  in_*         in       one command (clear or edge)
//  out_*        out      one result per command
//  cfg_*        in       register write, no handshake
//
// Clear and bad-coordinate items go from idle straight to the output state; an edge
// walks to each root with registered parent-memory reads, compresses the path, then
// links the roots. Before the first item after reset, and after every 15th clear, a
// sweep resets every entry of the memory.
// Either side may stall; a two-entry queue sits between the front and the back.
`default_nettype none
module grid_union_find_kruskal #(
  parameter int MAX_CELLS = gufk_pkg::MAX_CELLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_a_row,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_a_col,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_b_row,
  input  wire logic [gufk_pkg::COORD_W-1:0]  in_b_col,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_accepted,
  output logic [gufk_pkg::CNT_W-1:0]         out_clusters_left,
  output logic                               out_tree_done,
  output logic                               out_bad_coord,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [gufk_pkg::DIM_W-1:0]    cfg_data
);
  localparam int IDX_W = $clog2(MAX_CELLS);
  logic [gufk_pkg::DIM_W-1:0] rows_r, cols_r, clamped;
  logic           job_valid, job_take;
  gufk_pkg::job_t job;

  // Clamp dimension writes to 1..32
  always_comb begin
    if (cfg_data == '0) clamped = gufk_pkg::DIM_W'(1);
    else if (cfg_data > gufk_pkg::DIM_W'(gufk_pkg::GRID_DIM_MAX))
      clamped = gufk_pkg::DIM_W'(gufk_pkg::GRID_DIM_MAX);
    else clamped = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gufk_pkg::DIM_W'(gufk_pkg::GRID_DIM_MAX);
      cols_r <= gufk_pkg::DIM_W'(gufk_pkg::GRID_DIM_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gufk_pkg::REG_ROWS: rows_r <= clamped;
        gufk_pkg::REG_COLS: cols_r <= clamped;
        default: ;
      endcase
    end
  end

  gufk_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_a_row, .in_a_col,
    .in_b_row, .in_b_col, .rows(rows_r), .cols(cols_r),
    .job_valid, .job_take, .job
  );

  gufk_back #(.MAX_CELLS(MAX_CELLS), .IDX_W(IDX_W)) u_back (
    .clk, .rst_n, .job_valid, .job_take, .job, .rows(rows_r), .cols(cols_r),
    .out_valid, .out_stall, .out_accepted, .out_clusters_left,
    .out_tree_done, .out_bad_coord
  );
endmodule
`default_nettype wire

// ----- sim/grid_union_find_kruskal_tb.sv -----
// Testbench for grid_union_find_kruskal: directed and random clear/edge traffic
// checked against a cycle-free union-find predictor. Depends on gufk_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module grid_union_find_kruskal_tb;

  localparam int NCELLS = 1024;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic       accepted;
    logic [10:0] clusters;
    logic       done;
    logic       bad;
  } kres_t;

  // Predictor state plus expected-result queue.
  class forest_board;
    int unsigned link[NCELLS];
    bit          linked[NCELLS];
    int unsigned count;
    int unsigned rows, cols;
    kres_t       pending[$];
    int          errors;
    int          checked;
    int          merges;

    function void init();
      rows = 32; cols = 32;
      foreach (linked[i]) linked[i] = 0;
      count = NCELLS;
      errors = 0; checked = 0; merges = 0;
    endfunction

    function void set_reg(gufk_pkg::reg_idx_t idx, logic [5:0] v);
      int unsigned d;
      d = (v == 0) ? 1 : (v > 32 ? 32 : v);
      if (idx == gufk_pkg::REG_ROWS) rows = d; else cols = d;
    endfunction

    function int unsigned up(int unsigned x);
      if (!linked[x] || link[x] >= NCELLS) return x;
      return link[x];
    endfunction

    function int unsigned root_of(int unsigned x);
      int unsigned r, p, steps;
      r = x; steps = 0;
      while (steps < NCELLS) begin
        p = up(r);
        if (p == r) break;
        r = p; steps++;
      end
      steps = 0;
      while (x != r && steps < NCELLS) begin
        p = up(x);
        link[x] = r; linked[x] = 1;
        x = p; steps++;
      end
      return r;
    endfunction

    function bit to_cell(logic [4:0] r, logic [4:0] c, output int unsigned idx);
      idx = r * cols + c;
      return (r < rows && c < cols && idx < NCELLS);
    endfunction

    // Note one accepted input transaction.
    function void note_input(gufk_pkg::cmd_t cmd, logic [4:0] ar, ac, br, bc);
      kres_t e;
      int unsigned ia, ib, ra, rb, n;
      e.accepted = 0; e.bad = 0;
      if (cmd == gufk_pkg::CMD_CLEAR) begin
        foreach (linked[i]) linked[i] = 0;
        n = rows * cols;
        count = (n > NCELLS) ? NCELLS : n;
      end else if (!to_cell(ar, ac, ia) || !to_cell(br, bc, ib)) begin
        e.bad = 1;
      end else begin
        ra = root_of(ia);
        rb = root_of(ib);
        if (ra != rb) begin
          link[ra] = rb; linked[ra] = 1;
          e.accepted = 1; merges++;
          if (count > 0) count--;
        end
      end
      e.clusters = count[10:0];
      e.done = (count <= 1);
      pending.push_back(e);
    endfunction

    // Check one result transaction against the oldest expectation.
    function void check_result(kres_t got);
      kres_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result acc=%0d cl=%0d done=%0d bad=%0d",
                                   got.accepted, got.clusters, got.done, got.bad);
        return;
      end
      e = pending.pop_front();
      if (e.accepted !== got.accepted || e.clusters !== got.clusters ||
          e.done !== got.done || e.bad !== got.bad) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: exp acc=%0d cl=%0d done=%0d bad=%0d got acc=%0d cl=%0d done=%0d bad=%0d",
                   e.accepted, e.clusters, e.done, e.bad,
                   got.accepted, got.clusters, got.done, got.bad);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_cmd;
  logic [4:0] in_a_row, in_a_col, in_b_row, in_b_col;
  logic out_valid, out_stall, out_accepted, out_tree_done, out_bad_coord;
  logic [10:0] out_clusters_left;
  logic cfg_we, cfg_index;
  logic [5:0] cfg_data;

  forest_board board;
  int idle_cycles;
  bit stall_mode;
  int sent;

  grid_union_find_kruskal dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: alternating calm and busy stretches.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  // Result checking and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_result('{out_accepted, out_clusters_left, out_tree_done, out_bad_coord});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", board.pending.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Send one transaction and wait for its acceptance.
  task automatic send_item(gufk_pkg::cmd_t cmd, logic [4:0] ar, ac, br, bc);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_a_row <= ar; in_a_col <= ac; in_b_row <= br; in_b_col <= bc;
    do @(posedge clk); while (in_stall);
    board.note_input(cmd, ar, ac, br, bc);
    sent++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Wait until every expected result has come back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(gufk_pkg::reg_idx_t idx, logic [5:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Random edges: mostly in-grid neighbors, some arbitrary coordinates, occasional clears.
  task automatic random_phase(int n);
    int burst;
    logic [4:0] ar, ac, br, bc;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) == 0) pause_sender();
        burst = $urandom_range(1, 12);
      end
      burst--;
      if ($urandom_range(0, 40) == 0) begin
        send_item(gufk_pkg::CMD_CLEAR, 5'($urandom), 5'($urandom), 5'($urandom),
                  5'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        send_item(gufk_pkg::CMD_EDGE, 5'($urandom), 5'($urandom), 5'($urandom),
                  5'($urandom));
      end else begin
        ar = 5'($urandom_range(0, board.rows - 1));
        ac = 5'($urandom_range(0, board.cols - 1));
        br = ar; bc = ac;
        if ($urandom_range(0, 1)) br = (ar + 1 < board.rows) ? 5'(ar + 1) : ar;
        else bc = (ac + 1 < board.cols) ? 5'(ac + 1) : ac;
        if ($urandom_range(0, 3) == 0) begin
          br = 5'($urandom_range(0, board.rows - 1));
          bc = 5'($urandom_range(0, board.cols - 1));
        end
        send_item(gufk_pkg::CMD_EDGE, ar, ac, br, bc);
      end
    end
    drain();
  endtask

  initial begin
    board = new();
    board.init();
    rst_n = 0; in_valid = 0; in_cmd = gufk_pkg::CMD_CLEAR;
    in_a_row = 0; in_a_col = 0; in_b_row = 0; in_b_col = 0;
    out_stall = 0; stall_mode = 0; cfg_we = 0; cfg_index = gufk_pkg::REG_ROWS; cfg_data = 0;
    idle_cycles = 0; sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes on the reset 32x32 grid.
    send_item(gufk_pkg::CMD_EDGE, 0, 0, 0, 0);
    send_item(gufk_pkg::CMD_EDGE, 0, 0, 31, 31);
    send_item(gufk_pkg::CMD_EDGE, 31, 31, 0, 0);
    send_item(gufk_pkg::CMD_EDGE, 31, 0, 0, 31);
    send_item(gufk_pkg::CMD_EDGE, 0, 31, 31, 31);
    send_item(gufk_pkg::CMD_CLEAR, 31, 31, 31, 31);
    drain();

    // Small grid: out-of-range coordinates, full tree, then enlarge without clear.
    write_reg(gufk_pkg::REG_ROWS, 6'd0);
    write_reg(gufk_pkg::REG_COLS, 6'd2);
    send_item(gufk_pkg::CMD_CLEAR, 0, 0, 0, 0);
    send_item(gufk_pkg::CMD_EDGE, 1, 0, 0, 0);
    send_item(gufk_pkg::CMD_EDGE, 0, 2, 0, 0);
    send_item(gufk_pkg::CMD_EDGE, 0, 0, 0, 1);
    send_item(gufk_pkg::CMD_EDGE, 0, 1, 0, 0);
    send_item(gufk_pkg::CMD_EDGE, 0, 1, 0, 1);
    drain();
    write_reg(gufk_pkg::REG_ROWS, 6'd63);
    write_reg(gufk_pkg::REG_COLS, 6'd40);
    send_item(gufk_pkg::CMD_EDGE, 5, 5, 6, 6);
    send_item(gufk_pkg::CMD_EDGE, 7, 7, 8, 8);
    send_item(gufk_pkg::CMD_EDGE, 31, 31, 0, 0);
    drain();

    // Random phases over several grid shapes.
    write_reg(gufk_pkg::REG_ROWS, 6'd3); write_reg(gufk_pkg::REG_COLS, 6'd4);
    send_item(gufk_pkg::CMD_CLEAR, 0, 0, 0, 0);
    random_phase(500);
    write_reg(gufk_pkg::REG_ROWS, 6'd1); write_reg(gufk_pkg::REG_COLS, 6'd32);
    send_item(gufk_pkg::CMD_CLEAR, 0, 0, 0, 0);
    random_phase(400);
    write_reg(gufk_pkg::REG_ROWS, 6'd8); write_reg(gufk_pkg::REG_COLS, 6'd5);
    send_item(gufk_pkg::CMD_CLEAR, 0, 0, 0, 0);
    random_phase(600);
    write_reg(gufk_pkg::REG_ROWS, 6'd32); write_reg(gufk_pkg::REG_COLS, 6'd32);
    send_item(gufk_pkg::CMD_CLEAR, 0, 0, 0, 0);
    random_phase(500);

    $display("Sent %0d commands, %0d results checked, %0d edges merged, grids 1x2 to 32x32",
             sent, board.checked, board.merges);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
